// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the classifier RTL.
// Needs clk_i and rst_ni in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define LLC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("llc assertion failed");

`define LLC_ASSERT_IMP(lbl, ante, cons) `LLC_ASSERT(lbl, (ante) |-> (cons))

`endif

// ===== rtl/llc_pkg.sv =====
// Package for the log line classifier: sizes, result kinds, match strings,
// and the word passed from the front end to the back end. No dependencies.
package llc_pkg;

  localparam int LINE_CAPACITY = 128;
  localparam int CAPW          = $clog2(LINE_CAPACITY);
  localparam int QDEPTH        = 4;
  localparam int QW            = $clog2(QDEPTH);
  localparam int STRW          = 264;

  typedef enum logic [2:0] {
    KIND_NOT_LOG, KIND_TX, KIND_TX_BAD, KIND_SECTION,
    KIND_BOOT, KIND_READY, KIND_OTHER, KIND_TRUNC
  } kind_e;

  typedef enum logic [1:0] {PS_SPACE, PS_DIGIT, PS_DONE} pstate_e;

  localparam logic [7:0] CH_NL = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;

  localparam logic [STRW-1:0] S_LOG   = "LOG: ";
  localparam logic [STRW-1:0] S_TX    = "TX UHF:";
  localparam logic [STRW-1:0] S_LEN   = "len=";
  localparam logic [STRW-1:0] S_IFACE = "iface=";
  // boot banner prefix, 17 ASCII bytes
  localparam logic [STRW-1:0] S_BOOT  = STRW'(136'h5361744E4F47532D434F4D4D532046573A);
  localparam logic [STRW-1:0] S_READY = "All threads started successfully!";

  localparam logic [119:0] SEC_S [7] = '{
    "POWER", "RADIO", "HEALTH", "CONFIG", "FPGA", "TIME", "BOOTLOADER INFO"
  };
  localparam int SEC_L [7] = '{5, 5, 6, 6, 4, 4, 15};

  typedef struct packed {
    logic        trunc;
    logic        log_ok;
    logic        tx_pfx;
    logic        len_found;
    logic        len_neg;
    logic [31:0] len_val;
    logic        if_found;
    logic        if_neg;
    logic [31:0] if_val;
    logic [2:0]  sec_id;
    logic        boot;
    logic        ready;
    logic [6:0]  length;
  } rec_t;

  function automatic logic [7:0] str_ch(input logic [STRW-1:0] s, input int n,
                                        input int i);
    logic [7:0] r;
    r = 8'h00;
    if (i >= 0 && i < n) begin
      r = s[8*(n-1-i) +: 8];
    end
    return r;
  endfunction

endpackage

// ===== rtl/llc_front.sv =====
// Front end: line assembly and per-byte incremental matching and parsing.
// Emits one rec_t word per non-empty line end or truncation. Uses llc_pkg.
module llc_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  logic [7:0]    rx_byte_i,
  output logic          rec_valid_o,
  output llc_pkg::rec_t rec_o
);
  import llc_pkg::*;

  typedef struct packed {
    pstate_e     st;
    logic        neg;
    logic [31:0] v;
  } parse_t;

  typedef struct packed {
    logic            zs;
    logic [CAPW-1:0] endp;
    logic            lg;
    logic            tx;
    logic [6:0]      sec;
    logic            bn;
    logic            rd;
    logic [1:0]      lm;
    logic            lf;
    parse_t          lp;
    logic [2:0]      im;
    logic            imf;
    parse_t          ip;
  } mstate_t;

  localparam parse_t P_INIT = '{st: PS_SPACE, neg: 1'b0, v: 32'd0};
  localparam mstate_t M_INIT = '{zs: 1'b0, endp: '0, lg: 1'b1, tx: 1'b1,
                                 sec: 7'h7F, bn: 1'b1, rd: 1'b1, lm: 2'd0,
                                 lf: 1'b0, lp: P_INIT, im: 3'd0, imf: 1'b0,
                                 ip: P_INIT};

  function automatic parse_t pstep(input parse_t s, input logic [7:0] b);
    parse_t r;
    logic   dig;
    logic   ws;
    r   = s;
    dig = (b >= 8'h30) && (b <= 8'h39);
    ws  = (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
    unique case (s.st)
      PS_SPACE: begin
        if (ws) begin
          r.st = PS_SPACE;
        end else if (b == 8'h2B || b == 8'h2D) begin
          r.neg = (b == 8'h2D);
          r.st  = PS_DIGIT;
        end else if (dig) begin
          r.v  = {28'd0, b[3:0]};
          r.st = PS_DIGIT;
        end else begin
          r.st = PS_DONE;
        end
      end
      PS_DIGIT: begin
        if (dig) begin
          r.v = (s.v << 3) + (s.v << 1) + {28'd0, b[3:0]};
        end else begin
          r.st = PS_DONE;
        end
      end
      default: r = s;
    endcase
    return r;
  endfunction

  mstate_t         m_q, m_d, m_c;
  logic [CAPW-1:0] fill_q, fill_d;
  logic [7:0]      pend_q, pend_d;
  logic            is_nl, full_line, commit, pend_cr;
  int              p, cp, endi, clen, len_i;
  logic [7:0]      b;

  always_comb begin
    is_nl     = (rx_byte_i == CH_NL);
    full_line = (fill_q == CAPW'(LINE_CAPACITY - 1));
    pend_cr   = (pend_q == CH_CR);
    commit    = accept_i && (fill_q != '0) && (is_nl ? !pend_cr : !full_line);
    b         = pend_q;
    p         = int'(m_q.endp);
    cp        = p - 5;
    m_c       = m_q;
    if (commit && !m_q.zs) begin
      if (b == 8'h00) begin
        m_c.zs = 1'b1;
      end else begin
        m_c.endp = m_q.endp + 1'b1;
        if (p < 5) begin
          m_c.lg = m_q.lg && (b == str_ch(S_LOG, 5, p));
        end else begin
          m_c.tx = m_q.tx && ((cp >= 7) || (b == str_ch(S_TX, 7, cp)));
          for (int k = 0; k < 7; k++) begin
            m_c.sec[k] = m_q.sec[k] && ((cp >= SEC_L[k]) ||
                         (b == str_ch({144'd0, SEC_S[k]}, SEC_L[k], cp)));
          end
          m_c.bn = m_q.bn && ((cp >= 17) || (b == str_ch(S_BOOT, 17, cp)));
          m_c.rd = m_q.rd && ((cp >= 33) || (b == str_ch(S_READY, 33, cp)));
          if (!m_q.lf) begin
            if (b == str_ch(S_LEN, 4, int'(m_q.lm))) begin
              if (m_q.lm == 2'd3) m_c.lf = 1'b1;
              else m_c.lm = m_q.lm + 2'd1;
            end else begin
              m_c.lm = (b == str_ch(S_LEN, 4, 0)) ? 2'd1 : 2'd0;
            end
          end else begin
            m_c.lp = pstep(m_q.lp, b);
          end
          if (!m_q.imf) begin
            if (b == str_ch(S_IFACE, 6, int'(m_q.im))) begin
              if (m_q.im == 3'd5) m_c.imf = 1'b1;
              else m_c.im = m_q.im + 3'd1;
            end else begin
              m_c.im = (b == str_ch(S_IFACE, 6, 0)) ? 3'd1 : 3'd0;
            end
          end else begin
            m_c.ip = pstep(m_q.ip, b);
          end
        end
      end
    end
  end

  always_comb begin
    endi  = int'(m_c.endp);
    clen  = endi - 5;
    len_i = int'(fill_q) - ((fill_q != '0 && pend_cr) ? 1 : 0);
    rec_o = '0;
    if (is_nl) begin
      rec_o.log_ok    = m_c.lg && (endi >= 5);
      rec_o.tx_pfx    = m_c.tx && (clen >= 7);
      rec_o.len_found = m_c.lf;
      rec_o.len_neg   = m_c.lp.neg;
      rec_o.len_val   = m_c.lp.v;
      rec_o.if_found  = m_c.imf;
      rec_o.if_neg    = m_c.ip.neg;
      rec_o.if_val    = m_c.ip.v;
      for (int k = 6; k >= 0; k--) begin
        if (m_c.sec[k] && clen == SEC_L[k]) rec_o.sec_id = 3'(k + 1);
      end
      rec_o.boot   = m_c.bn && (clen >= 17);
      rec_o.ready  = m_c.rd && (clen == 33);
      rec_o.length = 7'(len_i);
    end else begin
      rec_o.trunc = 1'b1;
    end
    rec_valid_o = accept_i && (is_nl ? (len_i != 0) : full_line);
  end

  always_comb begin
    m_d    = m_q;
    fill_d = fill_q;
    pend_d = pend_q;
    if (accept_i) begin
      if (is_nl || full_line) begin
        m_d    = M_INIT;
        fill_d = '0;
      end else begin
        m_d    = m_c;
        pend_d = rx_byte_i;
        fill_d = fill_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_q    <= M_INIT;
      fill_q <= '0;
    end else begin
      m_q    <= m_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
  end

endmodule

// ===== rtl/llc_queue.sv =====
// Short queue of rec_t words between front and back end. Uses llc_pkg.
`include "assert_macros.svh"
module llc_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_i,
  input  llc_pkg::rec_t wdata_i,
  input  logic          rd_i,
  output llc_pkg::rec_t rdata_o,
  output logic          empty_o,
  output logic          full_o
);
  import llc_pkg::*;

  rec_t          mem_q [QDEPTH];
  logic [QW-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [QW:0]   cnt_q, cnt_d;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == (QW+1)'(QDEPTH));
  assign rdata_o = mem_q[rp_q];

  always_comb begin
    wp_d  = wr_i ? wp_q + 1'b1 : wp_q;
    rp_d  = rd_i ? rp_q + 1'b1 : rp_q;
    cnt_d = cnt_q + (QW+1)'(wr_i) - (QW+1)'(rd_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wp_q] <= wdata_i;
  end

  `LLC_ASSERT_IMP(a_no_overflow, wr_i && !rd_i, !full_o)
  `LLC_ASSERT_IMP(a_no_underflow, rd_i, !empty_o)
  `LLC_ASSERT(a_cnt_range, cnt_q <= (QW+1)'(QDEPTH))

endmodule

// ===== rtl/llc_back.sv =====
// Back end: final line kind, running counters, banner flag, result register.
// Uses llc_pkg.
`include "assert_macros.svh"
module llc_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          rec_valid_i,
  input  llc_pkg::rec_t rec_i,
  output logic          rec_take_o,
  input  logic          pop,
  output logic          empty,
  output logic [2:0]    line_kind_o,
  output logic [2:0]    section_id_o,
  output logic [31:0]   tx_length_o,
  output logic [31:0]   tx_interface_o,
  output logic [31:0]   log_lines_seen_o,
  output logic [31:0]   tx_reports_seen_o,
  output logic [6:0]    line_length_o
);
  import llc_pkg::*;

  logic        ov_q, ov_d;
  logic        ban_q, ban_d;
  logic [31:0] logc_q, logc_d, txc_q, txc_d;
  kind_e       kind_q, kind_d;
  logic [2:0]  sec_q, sec_d;
  logic [31:0] txl_q, txl_d, txi_q, txi_d;
  logic [6:0]  len_q, len_d;

  assign rec_take_o        = rec_valid_i && (!ov_q || pop);
  assign empty             = !ov_q;
  assign line_kind_o       = kind_q;
  assign section_id_o      = sec_q;
  assign tx_length_o       = txl_q;
  assign tx_interface_o    = txi_q;
  assign log_lines_seen_o  = logc_q;
  assign tx_reports_seen_o = txc_q;
  assign line_length_o     = len_q;

  always_comb begin
    ov_d   = ov_q && !pop;
    ban_d  = ban_q;
    logc_d = logc_q;
    txc_d  = txc_q;
    kind_d = kind_q;
    sec_d  = sec_q;
    txl_d  = txl_q;
    txi_d  = txi_q;
    len_d  = len_q;
    if (rec_take_o) begin
      ov_d  = 1'b1;
      sec_d = 3'd0;
      txl_d = 32'd0;
      txi_d = 32'd0;
      len_d = rec_i.length;
      priority if (rec_i.trunc) begin
        kind_d = KIND_TRUNC;
        len_d  = 7'd0;
      end else if (!rec_i.log_ok) begin
        kind_d = KIND_NOT_LOG;
      end else begin
        logc_d = logc_q + 32'd1;
        priority if (rec_i.tx_pfx) begin
          if (rec_i.len_found && rec_i.if_found) begin
            kind_d = KIND_TX;
            txl_d  = rec_i.len_neg ? 32'd0 - rec_i.len_val : rec_i.len_val;
            txi_d  = rec_i.if_neg ? 32'd0 - rec_i.if_val : rec_i.if_val;
            txc_d  = txc_q + 32'd1;
          end else begin
            kind_d = KIND_TX_BAD;
          end
        end else if (rec_i.sec_id != 3'd0) begin
          kind_d = KIND_SECTION;
          sec_d  = rec_i.sec_id;
        end else if (!ban_q && rec_i.boot) begin
          kind_d = KIND_BOOT;
          ban_d  = 1'b1;
        end else if (rec_i.ready) begin
          kind_d = KIND_READY;
        end else begin
          kind_d = KIND_OTHER;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q   <= 1'b0;
      ban_q  <= 1'b0;
      logc_q <= 32'd0;
      txc_q  <= 32'd0;
    end else begin
      ov_q   <= ov_d;
      ban_q  <= ban_d;
      logc_q <= logc_d;
      txc_q  <= txc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    sec_q  <= sec_d;
    txl_q  <= txl_d;
    txi_q  <= txi_d;
    len_q  <= len_d;
  end

  `LLC_ASSERT_IMP(a_trunc_len, ov_q && kind_q == KIND_TRUNC, len_q == 7'd0)
  `LLC_ASSERT_IMP(a_sec_kind, ov_q && sec_q != 3'd0, kind_q == KIND_SECTION)
  `LLC_ASSERT_IMP(a_hold, ov_q && !pop, ##1 ov_q && $stable(logc_q))

endmodule

// ===== rtl/log_line_classifier.sv =====
// Log line classifier: takes one serial byte per cycle while full is low
// (push/full) and gives one result word per non-empty line end or truncated
// line (empty/pop). Matching and number parsing run incrementally on the
// byte stream, one byte behind the input, so a line's result is written to a
// four-word queue in the cycle its newline is taken, then goes on to the result
// register once that register is empty or being popped. full rises only when
// that queue is full as results are not popped. Lines hold up to LINE_CAPACITY-1 bytes.
module log_line_classifier (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  rx_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  line_kind_o,
  output logic [2:0]  section_id_o,
  output logic [31:0] tx_length_o,
  output logic [31:0] tx_interface_o,
  output logic [31:0] log_lines_seen_o,
  output logic [31:0] tx_reports_seen_o,
  output logic [6:0]  line_length_o
);
  import llc_pkg::*;

  logic accept, rec_valid, q_empty, q_full, take;
  rec_t rec_w, rec_r;

  assign full   = q_full;
  assign accept = push && !q_full;

  llc_front u_front (
    .clk_i, .rst_ni,
    .accept_i   (accept),
    .rx_byte_i,
    .rec_valid_o(rec_valid),
    .rec_o      (rec_w)
  );

  llc_queue u_queue (
    .clk_i, .rst_ni,
    .wr_i   (rec_valid),
    .wdata_i(rec_w),
    .rd_i   (take),
    .rdata_o(rec_r),
    .empty_o(q_empty),
    .full_o (q_full)
  );

  llc_back u_back (
    .clk_i, .rst_ni,
    .rec_valid_i(!q_empty),
    .rec_i      (rec_r),
    .rec_take_o (take),
    .pop,
    .empty,
    .line_kind_o, .section_id_o, .tx_length_o, .tx_interface_o,
    .log_lines_seen_o, .tx_reports_seen_o, .line_length_o
  );

endmodule
